FILE: hw/rtl/csvp_pkg.sv
package csvp_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam int VALUE_WIDTH  = 32;
    localparam int REPORT_WIDTH = 16;
    localparam int ACC_WIDTH    = 36;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  value;
        logic                           has_value;
        logic                           end_of_line;
        logic [REPORT_WIDTH-1:0]        field_count;
    } csvp_result_t;

endpackage

FILE: hw/rtl/csv_signed_int_stream_parser_core.sv
// An accepted beat waits in the input register until the parser steps on it, and its
// result, from the multiply-by-ten-and-add and field logic, goes to the output register.
// Throughput: one character per cycle, unless a stalled output holds the parser.
// Characters that give no result are consumed without touching the output.
// Reset (rst_n low, asynchronous) empties both registers and clears the field state
// and the line's field count.
module csv_signed_int_stream_parser_core
    import csvp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               ch,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       value,
    output logic                     has_value,
    output logic                     end_of_line,
    output logic [15:0]              field_count
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   ch_reg;
    logic         out_valid_reg, out_valid_next;
    csvp_result_t result_reg;

    logic         emit;
    logic         step;
    logic         out_free;
    logic         in_accept;
    csvp_result_t result;

    csvp_field_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .ch     (ch_reg),
        .emit   (emit),
        .result (result)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    // advance the held character unless its result has nowhere to go
    assign step      = in_valid_reg && (!emit || out_free);
    assign in_stall  = in_valid_reg && !step;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            ch_reg <= ch;
        if (step && emit)
            result_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign value       = result_reg.value;
    assign has_value   = result_reg.has_value;
    assign end_of_line = result_reg.end_of_line;
    assign field_count = result_reg.field_count;

endmodule

FILE: hw/rtl/csvp_field_parser.sv
module csvp_field_parser
    import csvp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   ch,
    output logic         emit,
    output csvp_result_t result
);

    logic [31:0]            magnitude_reg, magnitude_next;
    logic                   negative_reg, negative_next;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   is_digit, is_minus, is_comma, is_cr;
    logic                   had_field;
    logic [ACC_WIDTH-1:0]   acc;
    logic [31:0]            cur_value;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [31:0]            count_ext;

    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_minus = (ch == CHAR_MINUS);
    assign is_comma = (ch == CHAR_COMMA);
    assign is_cr    = (ch == CHAR_CR);

    assign had_field = (phase_reg != PH_IDLE);

    // magnitude * 10 + digit, built from shifts
    assign acc = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
               + ACC_WIDTH'(ch - CHAR_ZERO);

    assign cur_value = negative_reg ? (32'd0 - magnitude_reg)
                     : ((magnitude_reg > POS_MAX) ? POS_MAX : magnitude_reg);

    // saturating field count
    assign count_inc = (had_field && (count_reg != '1)) ? count_reg + COUNT_WIDTH'(1)
                     : count_reg;
    assign count_ext = 32'(count_inc);

    assign emit = is_cr || (is_comma && had_field);

    always_comb
    begin
        result.value       = (had_field ? cur_value : 32'd0);
        result.has_value   = had_field;
        result.end_of_line = is_cr;
        result.field_count = (count_ext > 32'h0000_FFFF) ? '1 : count_ext[REPORT_WIDTH-1:0];
    end

    always_comb
    begin
        magnitude_next = magnitude_reg;
        negative_next  = negative_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        if (is_digit)
        begin
            if (phase_reg != PH_STOP)
            begin
                phase_next     = PH_DIGITS;
                magnitude_next = (acc > ACC_WIDTH'(MAG_LIMIT)) ? MAG_LIMIT : acc[31:0];
            end
        end
        else if (is_minus)
        begin
            if (phase_reg == PH_IDLE)
            begin
                negative_next = 1'b1;
                phase_next    = PH_SIGN;
            end
            else
            begin
                phase_next = PH_STOP;
            end
        end
        else if (is_comma || is_cr)
        begin
            magnitude_next = '0;
            negative_next  = 1'b0;
            phase_next     = PH_IDLE;
            count_next     = is_cr ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_reg <= '0;
            negative_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
        end
        else if (step)
        begin
            magnitude_reg <= magnitude_next;
            negative_reg  <= negative_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
        end
    end

endmodule
